[design/esud_pkg.sv]
// ----------------------------------------------------------------------------
// esud_pkg
// Shared constants, state encoding and calendar helpers for the epoch to
// UTC date converter.
// ----------------------------------------------------------------------------
package esud_pkg;

	// Default width of the seconds input and of the shared subtractor
	localparam int unsigned SECONDS_WIDTH_DEF = 32;

	// Time-of-day constants
	localparam int unsigned SECS_PER_DAY   = 86400;
	localparam int unsigned SECS_PER_HOUR  = 3600;
	localparam int unsigned SECS_PER_MIN   = 60;
	localparam int unsigned DAY_BITS       = 5;   // quotient bits of month seconds / 86400
	localparam int unsigned HOUR_BITS      = 5;   // quotient bits of day seconds / 3600
	localparam int unsigned MIN_BITS       = 6;   // quotient bits of hour seconds / 60

	// Calendar constants
	localparam int unsigned FIRST_YEAR        = 1970;
	localparam int unsigned FIRST_YEAR_MOD100 = 70;  // 1970 mod 100
	localparam int unsigned FIRST_CENT_MOD4   = 3;   // (1970 / 100) mod 4
	localparam int unsigned SECS_PER_COMMON_YEAR = 31536000;
	localparam int unsigned SECS_PER_LEAP_YEAR   = 31622400;
	localparam int unsigned YEAR_OUT_W        = 12;
	localparam logic [6:0]  LAST_YEAR_MOD100  = 7'd99;

	// Month lengths in seconds
	localparam logic [21:0] SECS_FEB_COMMON = 22'd2419200;
	localparam logic [21:0] SECS_FEB_LEAP   = 22'd2505600;
	localparam logic [21:0] SECS_MONTH_30   = 22'd2592000;
	localparam logic [21:0] SECS_MONTH_31   = 22'd2678400;

	// Month codes
	localparam logic [3:0] MON_JAN = 4'd0;
	localparam logic [3:0] MON_FEB = 4'd1;
	localparam logic [3:0] MON_APR = 4'd3;
	localparam logic [3:0] MON_JUN = 4'd5;
	localparam logic [3:0] MON_SEP = 4'd8;
	localparam logic [3:0] MON_NOV = 4'd10;
	localparam logic [3:0] MON_DEC = 4'd11;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_DONE
	} esud_state_t;

	// Seconds in a month, with February depending on the leap flag
	function automatic logic [21:0] month_secs(input logic [3:0] mon, input logic leap);
		logic [21:0] len;
		unique case (mon)
			MON_FEB: len = leap ? SECS_FEB_LEAP : SECS_FEB_COMMON;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = SECS_MONTH_30;
			default: len = SECS_MONTH_31;
		endcase
		return len;
	endfunction

endpackage

[design/esud_sub_unit.sv]
// ----------------------------------------------------------------------------
// esud_sub_unit
// Shared subtract-and-compare unit: gives a - b and whether a >= b.
// ----------------------------------------------------------------------------
module esud_sub_unit import esud_pkg::*; #(
	parameter int unsigned WIDTH = SECONDS_WIDTH_DEF
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic [WIDTH-1:0] diff,
	output logic             ge
);

	logic [WIDTH:0] full;

	// Subtract with one guard bit; no borrow means a >= b
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[WIDTH-1:0];
	assign ge   = ~full[WIDTH];

endmodule

[design/esud_seq.sv]
// ----------------------------------------------------------------------------
// esud_seq
// Sequencer and working registers: strip whole years and months off the
// seconds count, then find day, hour and minute digits by compare and
// subtract, all through the shared subtractor.
// ----------------------------------------------------------------------------
module esud_seq import esud_pkg::*; #(
	parameter int unsigned SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SECONDS_WIDTH-1:0] epoch_seconds,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SECONDS_WIDTH-1:0] sub_a,
	output logic [SECONDS_WIDTH-1:0] sub_b,
	input  logic [SECONDS_WIDTH-1:0] sub_diff,
	input  logic                     sub_ge,
	output logic [11:0]              year_full,
	output logic [3:0]               month_index,
	output logic [4:0]               month_day,
	output logic [4:0]               hour_of_day,
	output logic [5:0]               minute_of_hour,
	output logic [5:0]               second_of_minute
);

	localparam int unsigned CNT_W  = $clog2(MIN_BITS);
	localparam int unsigned YEAR_W = $clog2(FIRST_YEAR
		+ ((64'd1 << SECONDS_WIDTH) / 64'(SECS_PER_COMMON_YEAR)) + 2);

	esud_state_t state_q, state_d;

	logic [SECONDS_WIDTH-1:0] t_q;       // seconds left to strip
	logic [CNT_W-1:0]         cnt_q;     // step counter for digit loops
	logic [DAY_BITS-1:0]      day_q;
	logic [HOUR_BITS-1:0]     hour_q;
	logic [MIN_BITS-1:0]      min_q;
	logic [YEAR_W-1:0]        year_q;
	logic [6:0]               ymod100_q; // year mod 100
	logic [1:0]               cent4_q;   // century mod 4
	logic [3:0]               mon_q;
	logic                     leap;
	logic                     cnt_zero;

	// Gregorian leap rule from the tracked residues
	assign leap = (year_q[1:0] == 2'b00) && ((ymod100_q != '0) || (cent4_q == '0));
	assign cnt_zero = (cnt_q == '0);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_YEAR;
			ST_YEAR:  if (!sub_ge) state_d = ST_MONTH;
			ST_MONTH: if (!sub_ge || (mon_q == MON_DEC)) state_d = ST_DAY;
			ST_DAY:   if (cnt_zero) state_d = ST_HOUR;
			ST_HOUR:  if (cnt_zero) state_d = ST_MIN;
			ST_MIN:   if (cnt_zero) state_d = ST_DONE;
			ST_DONE:  if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake and subtractor operand select
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		sub_a     = t_q;
		sub_b     = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_YEAR: begin
				sub_b = leap ? SECONDS_WIDTH'(SECS_PER_LEAP_YEAR)
					: SECONDS_WIDTH'(SECS_PER_COMMON_YEAR);
			end
			ST_MONTH: begin
				sub_b = SECONDS_WIDTH'(month_secs(mon_q, leap));
			end
			ST_DAY: begin
				sub_b = SECONDS_WIDTH'(SECS_PER_DAY) << cnt_q;
			end
			ST_HOUR: begin
				sub_b = SECONDS_WIDTH'(SECS_PER_HOUR) << cnt_q;
			end
			ST_MIN: begin
				sub_b = SECONDS_WIDTH'(SECS_PER_MIN) << cnt_q;
			end
			ST_DONE: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					t_q       <= epoch_seconds;
					cnt_q     <= CNT_W'(DAY_BITS - 1);
					day_q     <= '0;
					hour_q    <= '0;
					min_q     <= '0;
					year_q    <= YEAR_W'(FIRST_YEAR);
					ymod100_q <= 7'(FIRST_YEAR_MOD100);
					cent4_q   <= 2'(FIRST_CENT_MOD4);
					mon_q     <= MON_JAN;
				end
			end
			ST_YEAR: begin
				// Strip one whole year and advance the residues
				if (sub_ge) begin
					t_q    <= sub_diff;
					year_q <= year_q + 1'b1;
					if (ymod100_q == LAST_YEAR_MOD100) begin
						ymod100_q <= '0;
						cent4_q   <= cent4_q + 1'b1;
					end else begin
						ymod100_q <= ymod100_q + 1'b1;
					end
				end
			end
			ST_MONTH: begin
				if (sub_ge && (mon_q != MON_DEC)) begin
					t_q   <= sub_diff;
					mon_q <= mon_q + 1'b1;
				end
			end
			ST_DAY: begin
				if (sub_ge) t_q <= sub_diff;
				day_q <= {day_q[DAY_BITS-2:0], sub_ge};
				cnt_q <= cnt_zero ? CNT_W'(HOUR_BITS - 1) : cnt_q - 1'b1;
			end
			ST_HOUR: begin
				if (sub_ge) t_q <= sub_diff;
				hour_q <= {hour_q[HOUR_BITS-2:0], sub_ge};
				cnt_q  <= cnt_zero ? CNT_W'(MIN_BITS - 1) : cnt_q - 1'b1;
			end
			ST_MIN: begin
				if (sub_ge) t_q <= sub_diff;
				min_q <= {min_q[MIN_BITS-2:0], sub_ge};
				if (!cnt_zero) cnt_q <= cnt_q - 1'b1;
			end
			ST_DONE: begin
				// hold result
			end
			default: begin
				// hold
			end
		endcase
	end

	// Result fields straight from the working registers
	assign year_full        = year_q[YEAR_OUT_W-1:0];
	assign month_index      = mon_q;
	assign month_day        = 5'(day_q + 5'd1);
	assign hour_of_day      = hour_q;
	assign minute_of_hour   = min_q;
	assign second_of_minute = t_q[5:0];

endmodule

[design/epoch_seconds_to_utc_date_unit.sv]
// Timing: from input transfer to out_valid the sequencer strips whole years,
//   then whole months, then finds the day, hour and minute digits.
// Throughput: one item at a time; the next item is taken in the cycle after the
//   result transfer. Year and month stripping through the single shared
//   subtractor sets how long an item takes.
// Reset: arst_n clears the sequencer to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date_unit
// Converts seconds since 1970-01-01 00:00:00 UTC to UTC year, month, day,
// hour, minute and second with one iterated subtract-and-compare unit.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_date_unit import esud_pkg::*; #(
	parameter int unsigned SECONDS_WIDTH = SECONDS_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SECONDS_WIDTH-1:0] epoch_seconds,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [11:0]              year_full,
	output logic [3:0]               month_index,
	output logic [4:0]               month_day,
	output logic [4:0]               hour_of_day,
	output logic [5:0]               minute_of_hour,
	output logic [5:0]               second_of_minute
);

	logic [SECONDS_WIDTH-1:0] sub_a;
	logic [SECONDS_WIDTH-1:0] sub_b;
	logic [SECONDS_WIDTH-1:0] sub_diff;
	logic                     sub_ge;

	// Shared subtract-and-compare unit
	esud_sub_unit #(
		.WIDTH (SECONDS_WIDTH)
	) u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	// Sequencer and working registers
	esud_seq #(
		.SECONDS_WIDTH (SECONDS_WIDTH)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sub_a            (sub_a),
		.sub_b            (sub_b),
		.sub_diff         (sub_diff),
		.sub_ge           (sub_ge),
		.year_full        (year_full),
		.month_index      (month_index),
		.month_day        (month_day),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute)
	);

endmodule

[design/esud_checker.sv]
// ----------------------------------------------------------------------------
// esud_checker
// Port-level checks for the epoch to UTC date converter, bound to the top.
// ----------------------------------------------------------------------------
module esud_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] year_full,
	input logic [3:0]  month_index,
	input logic [4:0]  month_day,
	input logic [4:0]  hour_of_day,
	input logic [5:0]  minute_of_hour,
	input logic [5:0]  second_of_minute
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(year_full)
			&& $stable(month_index) && $stable(month_day)
			&& $stable(hour_of_day) && $stable(minute_of_hour)
			&& $stable(second_of_minute))
		else $error("result changed while stalled");

	// Take no new item while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	// Never answer in the cycle after a transfer in
	a_multi_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid && !in_ready)
		else $error("result or ready right after input transfer");

	// Keep result fields in calendar range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_index <= 4'd11) && (month_day != 5'd0)
			&& (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59)
			&& (second_of_minute <= 6'd59))
		else $error("result field out of range");

endmodule

bind epoch_seconds_to_utc_date_unit esud_checker u_esud_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.year_full        (year_full),
	.month_index      (month_index),
	.month_day        (month_day),
	.hour_of_day      (hour_of_day),
	.minute_of_hour   (minute_of_hour),
	.second_of_minute (second_of_minute)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for epoch_seconds_to_utc_date_unit. A walked table of
// directed timestamps covers the epoch, the 32-bit limit, time-of-day edges,
// year ends and leap days, including the Gregorian century rule. Random
// timestamps follow, biased toward midnight and the top of the range. Both
// handshakes idle and stall at random. Every result is compared field by
// field against typed values or a calendar predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench import esud_pkg::*;;

	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned PRINT_CAP    = 50;
	localparam int unsigned DIRECTED_N   = 20;
	localparam logic [31:0] SECONDS_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} utc_stamp_t;

	typedef struct packed {
		logic [31:0] secs;
		logic        typed;
		utc_stamp_t  stamp;
	} date_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] year_full;
	logic [3:0]  month_index;
	logic [4:0]  month_day;
	logic [4:0]  hour_of_day;
	logic [5:0]  minute_of_hour;
	logic [5:0]  second_of_minute;

	utc_stamp_t  pending_dates[$];
	int unsigned err_count;
	int unsigned cycle_count;

	// Directed timestamps; expectations typed only for the epoch and the top
	date_row_t directed_rows [DIRECTED_N] = '{
		'{32'd0,          1'b1, '{12'd1970, MON_JAN, 5'd1, 5'd0, 6'd0, 6'd0}},
		'{SECONDS_MAX,    1'b1, '{12'd2106, MON_FEB, 5'd7, 5'd6, 6'd28, 6'd15}},
		'{32'd59,         1'b0, '0},
		'{32'd60,         1'b0, '0},
		'{32'd3599,       1'b0, '0},
		'{32'd3600,       1'b0, '0},
		'{32'd86399,      1'b0, '0},
		'{32'd86400,      1'b0, '0},
		'{32'd31535999,   1'b0, '0},
		'{32'd31536000,   1'b0, '0},
		'{32'd68169599,   1'b0, '0},
		'{32'd68169600,   1'b0, '0},
		'{32'd94694399,   1'b0, '0},
		'{32'd94694400,   1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'd978307199,  1'b0, '0},
		'{32'd4107542399, 1'b0, '0},
		'{32'd4107542400, 1'b0, '0},
		'{32'hAAAA_AAAA,  1'b0, '0},
		'{32'h5555_5555,  1'b0, '0}
	};

	epoch_seconds_to_utc_date_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.year_full        (year_full),
		.month_index      (month_index),
		.month_day        (month_day),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gregorian rule: every 4th year, not every 100th, but every 400th
	function automatic bit gregorian_leap(input int unsigned yr);
		return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned yr,
			input logic [3:0] mon);
		int unsigned lens [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (mon == MON_FEB && gregorian_leap(yr))
			return 29;
		return lens[mon];
	endfunction

	// Split off whole days, then peel whole years and months
	function automatic utc_stamp_t utc_from_seconds(input logic [31:0] secs);
		int unsigned days;
		int unsigned rem;
		int unsigned yr;
		int unsigned span;
		logic [3:0]  mon;
		utc_stamp_t  st;
		days = secs / SECS_PER_DAY;
		rem  = secs % SECS_PER_DAY;
		yr   = FIRST_YEAR;
		span = gregorian_leap(yr) ? 366 : 365;
		while (days >= span) begin
			days -= span;
			yr++;
			span = gregorian_leap(yr) ? 366 : 365;
		end
		mon  = MON_JAN;
		span = days_in_month(yr, mon);
		while (mon != MON_DEC && days >= span) begin
			days -= span;
			mon++;
			span = days_in_month(yr, mon);
		end
		st.year   = yr[11:0];
		st.month  = mon;
		st.day    = 5'(days + 1);
		st.hour   = 5'(rem / SECS_PER_HOUR);
		st.minute = 6'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
		st.second = 6'(rem % SECS_PER_MIN);
		return st;
	endfunction

	// Bias random timestamps toward midnight and the top of the range
	function automatic logic [31:0] pick_seconds();
		longint unsigned v;
		int unsigned     kind;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			v = $urandom;
		end else if (kind <= 8) begin
			v = longint'($urandom_range(0, 49710)) * SECS_PER_DAY;
			v += $urandom_range(0, 1) ? $urandom_range(0, 3)
					: SECS_PER_DAY - 1 - $urandom_range(0, 3);
			if (v > SECONDS_MAX)
				v = SECONDS_MAX;
		end else begin
			v = SECONDS_MAX - $urandom_range(0, 20_000_000);
		end
		return v[31:0];
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (err_count < PRINT_CAP)
			$display("cycle %0d: %s got %0d want %0d", cycle_count, field, got, want);
		err_count++;
	endtask

	// Hold valid and payload until the transfer, then queue the expected date
	int unsigned send_quiet;
	task automatic send_date(input logic [31:0] secs, input logic typed,
			input utc_stamp_t want);
		int unsigned gap;
		if (send_quiet == 0 && $urandom_range(0, 15) == 0)
			send_quiet = $urandom_range(20, 60);
		gap = 0;
		if (send_quiet > 0)
			send_quiet--;
		else
			gap = $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (!in_ready);
		pending_dates.push_back(typed ? want : utc_from_seconds(secs));
	endtask

	// Stall the result side at random, with quiet stretches
	initial begin : result_stall
		int unsigned stall;
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		forever begin
			if (quiet == 0 && $urandom_range(0, 15) == 0)
				quiet = $urandom_range(20, 60);
			stall = 0;
			if (quiet > 0)
				quiet--;
			else
				stall = $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		utc_stamp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_dates.size() == 0) begin
				report_mismatch("unexpected result, year_full", year_full, 0);
			end else begin
				want = pending_dates.pop_front();
				if (year_full != want.year)
					report_mismatch("year_full", year_full, want.year);
				if (month_index != want.month)
					report_mismatch("month_index", month_index, want.month);
				if (month_day != want.day)
					report_mismatch("month_day", month_day, want.day);
				if (hour_of_day != want.hour)
					report_mismatch("hour_of_day", hour_of_day, want.hour);
				if (minute_of_hour != want.minute)
					report_mismatch("minute_of_hour", minute_of_hour, want.minute);
				if (second_of_minute != want.second)
					report_mismatch("second_of_minute", second_of_minute, want.second);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("epoch_seconds_to_utc_date_unit: mismatch");
			$finish;
		end
	end

	// Reset, directed table, random timestamps, drain
	initial begin
		err_count     = 0;
		cycle_count   = 0;
		send_quiet    = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		out_ready     = 1'b0;
		epoch_seconds = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_date(directed_rows[i].secs, directed_rows[i].typed,
					directed_rows[i].stamp);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_date(pick_seconds(), 1'b0, '0);
		in_valid <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("epoch_seconds_to_utc_date_unit: match");
		else
			$display("epoch_seconds_to_utc_date_unit: mismatch");
		$finish;
	end

endmodule
